>>> sv/length_prefixed_string_to_utf8_core_assert.svh
// ---------------------------------------------------------------------------
// length_prefixed_string_to_utf8_core_assert
// assertion macros shared by the string decoder, clocked on clk, off in reset
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_STRING_TO_UTF8_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_STRING_TO_UTF8_CORE_ASSERT_SVH

// condition holds at every edge
`define LPSU8_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LPSU8_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> sv/lpsu8_pkg.sv
// ---------------------------------------------------------------------------
// lpsu8_pkg
// types and constants of the tagged string to utf-8 decoder
// ---------------------------------------------------------------------------
`default_nettype none

package lpsu8_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       field_start;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic        status;
    logic [15:0] consumed_length;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SHORT,
    PH_LHDR,
    PH_LBODY
  } phase_t;

  localparam int CAP_W    = 13;
  localparam int CP_W     = 21;
  localparam int LEN_W    = 16;
  localparam int PUSH_MAX = 3;
  localparam int QDEPTH   = 8;
  localparam int QAW      = 3;
  localparam int QCW      = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 13'd256;

  localparam logic [7:0] FLAG_EMPTY     = 8'h00;
  localparam logic [7:0] FLAG_EMPTY_ALT = 8'h40;
  localparam int         FLAG_WIDE_BIT  = 4;
  localparam int         FLAG_LE_BIT    = 7;

  localparam logic [LEN_W-1:0] LONG_OVERHEAD = 16'd4;

  localparam logic [15:0] SURR_HI_FIRST = 16'hD800;
  localparam logic [15:0] SURR_HI_LAST  = 16'hDBFF;
  localparam logic [15:0] SURR_LO_FIRST = 16'hDC00;
  localparam logic [15:0] SURR_LO_LAST  = 16'hDFFF;
  localparam logic [15:0] UNIT_BACKSLASH = 16'h005C;
  localparam logic [15:0] UNIT_SLASH     = 16'h002F;

  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;
  localparam logic [CP_W-1:0] CP_MAX1   = 21'h00007F;
  localparam logic [CP_W-1:0] CP_MAX2   = 21'h0007FF;
  localparam logic [CP_W-1:0] CP_MAX3   = 21'h00FFFF;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  // one queued command: a code point to encode or a field close
  typedef struct packed {
    logic             is_close;
    logic [CP_W-1:0]  cp;
    logic [1:0]       len_m1;
    logic             status;
    logic [LEN_W-1:0] cons;
  } cmd_t;

  typedef struct packed {
    logic [1:0]                n;
    cmd_t [PUSH_MAX-1:0]       cmd;
  } q_push_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

`default_nettype wire

>>> sv/lpsu8_front.sv
// ---------------------------------------------------------------------------
// lpsu8_front
// field parser: takes one source byte per cycle while the queue has room
// and pushes up to three commands (code points or closes) into the command queue
// ---------------------------------------------------------------------------
`default_nettype none

module lpsu8_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [12:0]              cfg_wdata,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire lpsu8_pkg::in_item_t      in_data,
  input  wire logic                     q_room,
  output lpsu8_pkg::q_push_t            q_push
);

  lpsu8_pkg::phase_t phase_r, phase_nxt;
  logic [12:0] cap_r;
  logic [7:0]  flag_r, flag_nxt;
  logic [15:0] decl_r, decl_nxt;
  logic [15:0] seen_r, seen_nxt;
  logic [12:0] cnt_r, cnt_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [15:0] hs_r, hs_nxt;
  logic        hp_r, hp_nxt;
  logic        stop_r, stop_nxt;
  logic        acc;
  logic        tail_close;
  logic [12:0] cap_e;

  function automatic logic [2:0] cp_len(input logic [20:0] cp);
    logic [2:0] l;
    if (cp <= lpsu8_pkg::CP_MAX1) l = 3'd1;
    else if (cp <= lpsu8_pkg::CP_MAX2) l = 3'd2;
    else if (cp <= lpsu8_pkg::CP_MAX3) l = 3'd3;
    else l = 3'd4;
    return l;
  endfunction

  assign acc      = in_valid && q_room;
  assign in_stall = !q_room;
  assign cap_e    = (cap_r == '0) ? 13'd1 : cap_r;

  // datapath and command generation
  always_comb begin
    lpsu8_pkg::cmd_t [2:0] cmd_v;
    logic [1:0]  n;
    logic [7:0]  b;
    logic [15:0] u;
    logic [20:0] cpv;
    logic [2:0]  ln;
    logic [13:0] sum;
    logic        go;
    flag_nxt   = flag_r;
    decl_nxt   = decl_r;
    seen_nxt   = seen_r;
    cnt_nxt    = cnt_r;
    low_nxt    = low_r;
    hs_nxt     = hs_r;
    hp_nxt     = hp_r;
    stop_nxt   = stop_r;
    cmd_v      = '0;
    n          = '0;
    b          = in_data.in_byte;
    u          = '0;
    cpv        = '0;
    ln         = '0;
    sum        = '0;
    go         = 1'b0;
    tail_close = 1'b0;
    if (acc) begin
      if (in_data.field_start) begin
        if (phase_r != lpsu8_pkg::PH_IDLE) begin
          cmd_v[n] = '{is_close: 1'b1, cp: '0, len_m1: '0, status: 1'b1,
                       cons: (phase_r == lpsu8_pkg::PH_LHDR || decl_r == '0) ? 16'd1 : decl_r};
          n = n + 2'd1;
        end
        flag_nxt = b;
        seen_nxt = '0;
        cnt_nxt  = '0;
        low_nxt  = '0;
        hs_nxt   = '0;
        hp_nxt   = 1'b0;
        stop_nxt = 1'b0;
        decl_nxt = '0;
        if (b == lpsu8_pkg::FLAG_EMPTY || b == lpsu8_pkg::FLAG_EMPTY_ALT) begin
          cmd_v[n] = '{is_close: 1'b1, cp: '0, len_m1: '0, status: 1'b0, cons: 16'd1};
          n = n + 2'd1;
          tail_close = 1'b1;
        end else if (b[0]) begin
          decl_nxt = {9'd0, b[7:1]};
          if (b[7:2] == '0) begin
            cmd_v[n] = '{is_close: 1'b1, cp: '0, len_m1: '0, status: 1'b0, cons: 16'd1};
            n = n + 2'd1;
            tail_close = 1'b1;
          end else if (in_data.buffer_end) begin
            cmd_v[n] = '{is_close: 1'b1, cp: '0, len_m1: '0, status: 1'b1, cons: decl_nxt};
            n = n + 2'd1;
            tail_close = 1'b1;
          end
        end else if (in_data.buffer_end) begin
          cmd_v[n] = '{is_close: 1'b1, cp: '0, len_m1: '0, status: 1'b1, cons: 16'd1};
          n = n + 2'd1;
          tail_close = 1'b1;
        end
      end else begin
        case (phase_r)
          lpsu8_pkg::PH_SHORT: begin
            seen_nxt = seen_r + 16'd1;
            if (!stop_nxt) begin
              if (b == '0 || ({1'b0, cnt_nxt} + 14'd1) >= {1'b0, cap_e}) begin
                stop_nxt = 1'b1;
              end else begin
                cmd_v[n] = '{is_close: 1'b0, cp: {13'd0, b}, len_m1: '0, status: 1'b0,
                             cons: '0};
                n = n + 2'd1;
                cnt_nxt = cnt_nxt + 13'd1;
              end
            end
            if (seen_nxt == decl_r - 16'd1) begin
              cmd_v[n] = '{is_close: 1'b1, cp: '0, len_m1: '0, status: 1'b0, cons: decl_r};
              n = n + 2'd1;
              tail_close = 1'b1;
            end else if (in_data.buffer_end) begin
              cmd_v[n] = '{is_close: 1'b1, cp: '0, len_m1: '0, status: 1'b1, cons: decl_r};
              n = n + 2'd1;
              tail_close = 1'b1;
            end
          end
          lpsu8_pkg::PH_LHDR: begin
            seen_nxt = seen_r + 16'd1;
            if (seen_r == 16'd0 || seen_r == 16'd1) begin
              if (seen_r == 16'd0) decl_nxt = {8'd0, b};
              else decl_nxt = {b, decl_r[7:0]};
              if (in_data.buffer_end) begin
                cmd_v[n] = '{is_close: 1'b1, cp: '0, len_m1: '0, status: 1'b1, cons: 16'd1};
                n = n + 2'd1;
                tail_close = 1'b1;
              end
            end else if (decl_r <= lpsu8_pkg::LONG_OVERHEAD) begin
              cmd_v[n] = '{is_close: 1'b1, cp: '0, len_m1: '0, status: 1'b0,
                           cons: (decl_r == '0) ? 16'd1 : decl_r};
              n = n + 2'd1;
              tail_close = 1'b1;
            end else begin
              seen_nxt = '0;
              if (in_data.buffer_end) begin
                cmd_v[n] = '{is_close: 1'b1, cp: '0, len_m1: '0, status: 1'b1, cons: decl_r};
                n = n + 2'd1;
                tail_close = 1'b1;
              end
            end
          end
          lpsu8_pkg::PH_LBODY: begin
            seen_nxt = seen_r + 16'd1;
            if (flag_r[lpsu8_pkg::FLAG_WIDE_BIT]) begin
              if (seen_nxt[0]) begin
                low_nxt = b;
              end else begin
                u = flag_r[lpsu8_pkg::FLAG_LE_BIT] ? {b, low_r} : {low_r, b};
                if (!stop_nxt) begin
                  go = 1'b1;
                  if (hp_nxt) begin
                    hp_nxt = 1'b0;
                    if (u >= lpsu8_pkg::SURR_LO_FIRST && u <= lpsu8_pkg::SURR_LO_LAST) begin
                      cpv = lpsu8_pkg::SUPP_BASE + {1'b0, hs_nxt[9:0], u[9:0]};
                      go  = 1'b0;
                    end else begin
                      cpv = {5'd0, hs_nxt};
                    end
                    ln  = cp_len(cpv);
                    sum = {1'b0, cnt_nxt} + {11'd0, ln};
                    if (sum >= {1'b0, cap_e}) begin
                      stop_nxt = 1'b1;
                    end else begin
                      cmd_v[n] = '{is_close: 1'b0, cp: cpv, len_m1: 2'(ln - 3'd1),
                                   status: 1'b0, cons: '0};
                      n = n + 2'd1;
                      cnt_nxt = sum[12:0];
                    end
                    if (stop_nxt) go = 1'b0;
                  end
                  if (go) begin
                    if (u == '0) begin
                      stop_nxt = 1'b1;
                    end else if (u >= lpsu8_pkg::SURR_HI_FIRST &&
                                 u <= lpsu8_pkg::SURR_HI_LAST) begin
                      hp_nxt = 1'b1;
                      hs_nxt = u;
                    end else begin
                      cpv = {5'd0, (u == lpsu8_pkg::UNIT_BACKSLASH) ? lpsu8_pkg::UNIT_SLASH : u};
                      ln  = cp_len(cpv);
                      sum = {1'b0, cnt_nxt} + {11'd0, ln};
                      if (sum >= {1'b0, cap_e}) begin
                        stop_nxt = 1'b1;
                      end else begin
                        cmd_v[n] = '{is_close: 1'b0, cp: cpv, len_m1: 2'(ln - 3'd1),
                                     status: 1'b0, cons: '0};
                        n = n + 2'd1;
                        cnt_nxt = sum[12:0];
                      end
                    end
                  end
                end
              end
            end else if (!stop_nxt) begin
              if (b == '0 || ({1'b0, cnt_nxt} + 14'd1) >= {1'b0, cap_e}) begin
                stop_nxt = 1'b1;
              end else begin
                cmd_v[n] = '{is_close: 1'b0, cp: {13'd0, b}, len_m1: '0, status: 1'b0,
                             cons: '0};
                n = n + 2'd1;
                cnt_nxt = cnt_nxt + 13'd1;
              end
            end
            if (seen_nxt == decl_r - lpsu8_pkg::LONG_OVERHEAD) begin
              // unpaired high surrogate at the end of the data
              if (flag_r[lpsu8_pkg::FLAG_WIDE_BIT] && hp_nxt && !stop_nxt) begin
                hp_nxt = 1'b0;
                cpv = {5'd0, hs_nxt};
                ln  = cp_len(cpv);
                sum = {1'b0, cnt_nxt} + {11'd0, ln};
                if (sum >= {1'b0, cap_e}) begin
                  stop_nxt = 1'b1;
                end else begin
                  cmd_v[n] = '{is_close: 1'b0, cp: cpv, len_m1: 2'(ln - 3'd1),
                               status: 1'b0, cons: '0};
                  n = n + 2'd1;
                  cnt_nxt = sum[12:0];
                end
              end
              cmd_v[n] = '{is_close: 1'b1, cp: '0, len_m1: '0, status: 1'b0, cons: decl_r};
              n = n + 2'd1;
              tail_close = 1'b1;
            end else if (in_data.buffer_end) begin
              cmd_v[n] = '{is_close: 1'b1, cp: '0, len_m1: '0, status: 1'b1, cons: decl_r};
              n = n + 2'd1;
              tail_close = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (tail_close) begin
        hp_nxt  = 1'b0;
        hs_nxt  = '0;
        low_nxt = '0;
      end
    end
    q_push.n   = n;
    q_push.cmd = cmd_v;
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      if (tail_close) begin
        phase_nxt = lpsu8_pkg::PH_IDLE;
      end else if (in_data.field_start) begin
        phase_nxt = in_data.in_byte[0] ? lpsu8_pkg::PH_SHORT : lpsu8_pkg::PH_LHDR;
      end else if (phase_r == lpsu8_pkg::PH_LHDR && seen_r == 16'd2) begin
        phase_nxt = lpsu8_pkg::PH_LBODY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lpsu8_pkg::PH_IDLE;
      cap_r   <= lpsu8_pkg::CAP_RESET;
      flag_r  <= '0;
      decl_r  <= '0;
      seen_r  <= '0;
      cnt_r   <= '0;
      low_r   <= '0;
      hs_r    <= '0;
      hp_r    <= 1'b0;
      stop_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
      flag_r  <= flag_nxt;
      decl_r  <= decl_nxt;
      seen_r  <= seen_nxt;
      cnt_r   <= cnt_nxt;
      low_r   <= low_nxt;
      hs_r    <= hs_nxt;
      hp_r    <= hp_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/lpsu8_queue.sv
// ---------------------------------------------------------------------------
// lpsu8_queue
// command queue between parser and encoder, up to three writes per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module lpsu8_queue (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire lpsu8_pkg::q_push_t     q_push,
  input  wire logic                   q_pop,
  output logic                        q_room,
  output lpsu8_pkg::q_head_t          q_head
);

  lpsu8_pkg::cmd_t             mem_r [lpsu8_pkg::QDEPTH];
  logic [lpsu8_pkg::QAW-1:0]   wr_r, wr_nxt;
  logic [lpsu8_pkg::QAW-1:0]   rd_r, rd_nxt;
  logic [lpsu8_pkg::QCW-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt  = wr_r + lpsu8_pkg::QAW'(q_push.n);
    rd_nxt  = rd_r + lpsu8_pkg::QAW'(q_pop);
    cnt_nxt = cnt_r + lpsu8_pkg::QCW'(q_push.n) - lpsu8_pkg::QCW'(q_pop);
  end

  assign q_room       = cnt_r <= lpsu8_pkg::QCW'(lpsu8_pkg::QDEPTH - lpsu8_pkg::PUSH_MAX);
  assign q_head.valid = cnt_r != '0;
  assign q_head.cmd   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    for (int i = 0; i < lpsu8_pkg::PUSH_MAX; i++) begin
      if (2'(i) < q_push.n) mem_r[wr_r + lpsu8_pkg::QAW'(i)] <= q_push.cmd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/lpsu8_back.sv
// ---------------------------------------------------------------------------
// lpsu8_back
// utf-8 encoder: expands each queued command into result transfers,
// one per cycle while out_stall is low, through a registered output stage
// ---------------------------------------------------------------------------
`default_nettype none

module lpsu8_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire lpsu8_pkg::q_head_t     q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output lpsu8_pkg::out_item_t        out_data
);

  logic [1:0]              idx_r, idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  lpsu8_pkg::out_item_t    out_data_r, out_data_nxt;
  logic                    load;
  logic [7:0]              enc;

  always_comb begin
    logic [20:0] cp;
    cp  = q_head.cmd.cp;
    enc = '0;
    case (q_head.cmd.len_m1)
      2'd0: enc = cp[7:0];
      2'd1: begin
        case (idx_r)
          2'd0:    enc = lpsu8_pkg::UTF8_LEAD2 | {3'd0, cp[10:6]};
          default: enc = lpsu8_pkg::UTF8_CONT | {2'd0, cp[5:0]};
        endcase
      end
      2'd2: begin
        case (idx_r)
          2'd0:    enc = lpsu8_pkg::UTF8_LEAD3 | {4'd0, cp[15:12]};
          2'd1:    enc = lpsu8_pkg::UTF8_CONT | {2'd0, cp[11:6]};
          default: enc = lpsu8_pkg::UTF8_CONT | {2'd0, cp[5:0]};
        endcase
      end
      default: begin
        case (idx_r)
          2'd0:    enc = lpsu8_pkg::UTF8_LEAD4 | {5'd0, cp[20:18]};
          2'd1:    enc = lpsu8_pkg::UTF8_CONT | {2'd0, cp[17:12]};
          2'd2:    enc = lpsu8_pkg::UTF8_CONT | {2'd0, cp[11:6]};
          default: enc = lpsu8_pkg::UTF8_CONT | {2'd0, cp[5:0]};
        endcase
      end
    endcase
  end

  always_comb begin
    load          = !out_valid_r || !out_stall;
    q_pop         = 1'b0;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt = q_head.valid;
      if (q_head.valid) begin
        if (q_head.cmd.is_close) begin
          out_data_nxt = '{out_byte: '0, byte_valid: 1'b0, last: 1'b1,
                           status: q_head.cmd.status, consumed_length: q_head.cmd.cons};
        end else begin
          out_data_nxt = '{out_byte: enc, byte_valid: 1'b1, last: 1'b0,
                           status: 1'b0, consumed_length: '0};
        end
        if (q_head.cmd.is_close || idx_r == q_head.cmd.len_m1) begin
          q_pop   = 1'b1;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/length_prefixed_string_to_utf8_core.sv
// ---------------------------------------------------------------------------
// length_prefixed_string_to_utf8_core
// decodes tagged string fields (short ascii, long ascii or utf-16) to utf-8
// ---------------------------------------------------------------------------
// The parser takes one source byte per cycle whenever the command queue
// (eight entries) has room for three more commands; a byte yields up to three
// commands (code points and field closes). The encoder drains the queue and
// sends one result transfer per cycle while out_stall is low, so a byte that
// causes several results lets the parser run ahead of the encoder until the
// queue is short of room, and the sustained rate is set by the encoder's
// output port. A result passes through the queue memory and then the encoder's
// output register after the byte that causes it.
// output_capacity is written through cfg_we/cfg_wdata and resets to 256.
`default_nettype none

`include "length_prefixed_string_to_utf8_core_assert.svh"

module length_prefixed_string_to_utf8_core (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [12:0]            cfg_wdata,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire lpsu8_pkg::in_item_t    in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output lpsu8_pkg::out_item_t        out_data
);

  lpsu8_pkg::q_push_t q_push;
  lpsu8_pkg::q_head_t q_head;
  logic               q_room;
  logic               q_pop;

  lpsu8_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_room    (q_room),
    .q_push    (q_push)
  );

  lpsu8_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_pop  (q_pop),
    .q_room (q_room),
    .q_head (q_head)
  );

  lpsu8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `LPSU8_ASSERT_IMPLY(a_push_only_on_transfer, q_push.n != 2'd0, in_valid && !in_stall, "commands pushed without an input transfer")
  `LPSU8_ASSERT_ALWAYS(a_no_pop_when_empty, !(q_pop && !q_head.valid), "encoder popped an empty queue")
  `LPSU8_ASSERT_IMPLY(a_close_has_length, out_valid && out_data.last, !out_data.byte_valid && out_data.consumed_length != 16'd0, "close item malformed")

endmodule

`default_nettype wire
